/* src/spfa_shortest_path_engine_top_macros.svh */
// assertion macros for the shortest path engine
`ifndef SPFA_SHORTEST_PATH_ENGINE_TOP_MACROS_SVH
`define SPFA_SHORTEST_PATH_ENGINE_TOP_MACROS_SVH

// clocked check, off while in reset
`define SPFA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked implication checked on the following cycle
`define SPFA_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* src/spfa_pkg.sv */
// ---------------------------------------------------------------------------
// spfa_pkg
// shared opcodes, field widths and distance constants
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package spfa_pkg;
  localparam int OP_W     = 2;
  localparam int NODE_W   = 10;
  localparam int COST_W   = 21;
  localparam int LIMIT_W  = 21;
  localparam int OUT_D_W  = 32;
  localparam int STATUS_W = 2;
  localparam int INF_W    = 29;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_RUN   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LIMIT   = 2'd2;

  localparam logic [INF_W-1:0]   INF_DIST      = 29'h0fffffff;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 21'h100000;
endpackage
`default_nettype wire

/* src/spfa_ram.sv */
// ---------------------------------------------------------------------------
// spfa_ram
// simple dual port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module spfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* src/spfa_shortest_path_engine_top.sv */
// ---------------------------------------------------------------------------
// spfa_shortest_path_engine_top
// queue based bellman-ford shortest path engine over adjacency lists
// ---------------------------------------------------------------------------
// Commands are taken when start is high and busy is low; busy stays high
// while a command works. After reset and after each clear the list heads are
// swept over every node. An add edge writes the edge and its list head; a
// dropped edge leaves busy low. A run sets every distance to infinity and
// queues the source, then dequeues nodes and walks their edges, each edge step
// a read and write of the distance memory. Once the queue is found empty or
// the limit reached, the target is read; the result shows for one cycle on
// out_valid and cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "spfa_shortest_path_engine_top_macros.svh"
module spfa_shortest_path_engine_top
  import spfa_pkg::*;
#(
  parameter int NODES     = 1024,
  parameter int EDGES     = 4096,
  parameter int DIST_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [OP_W-1:0]     in_opcode,
  input  wire logic [NODE_W-1:0]   in_from_node,
  input  wire logic [NODE_W-1:0]   in_to_node,
  input  wire logic signed [COST_W-1:0] in_weight,
  output logic                     out_valid,
  output logic signed [OUT_D_W-1:0] out_distance,
  output logic                     out_reachable,
  output logic [STATUS_W-1:0]      out_status,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  localparam int NB  = $clog2(NODES);
  localparam int EB  = $clog2(EDGES);
  localparam int CB  = $clog2(EDGES + 1);
  localparam int QB  = $clog2(NODES + 1);
  localparam int DW  = (DIST_BITS > INF_W) ? DIST_BITS : INF_W;
  localparam int NMW = DW + 1;
  localparam int HW  = EB + 1;
  localparam int EW  = NB + EB + 1 + COST_W;

  localparam logic signed [DW:0] MAXV =
    {{(DW - DIST_BITS + 2){1'b0}}, {(DIST_BITS - 1){1'b1}}};
  localparam logic signed [DW:0] MINV = ~MAXV;
  localparam logic signed [DW-1:0] INF_V = DW'(INF_DIST);
  localparam logic [NB-1:0] NODE_LAST = NB'(NODES - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_ADD  = 4'd2;
  localparam logic [3:0] S_INIT = 4'd3;
  localparam logic [3:0] S_SEED = 4'd4;
  localparam logic [3:0] S_DEQ  = 4'd5;
  localparam logic [3:0] S_DQ1  = 4'd6;
  localparam logic [3:0] S_DQ2  = 4'd7;
  localparam logic [3:0] S_E1   = 4'd8;
  localparam logic [3:0] S_E2   = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  function automatic logic [NB-1:0] node_wrap(input logic [NODE_W-1:0] v);
    logic [31:0] r;
    r = 32'(v);
    for (int k = NODE_W; k >= 0; k--) begin
      if (r >= (32'(NODES) << k)) begin
        r = r - (32'(NODES) << k);
      end
    end
    return r[NB-1:0];
  endfunction

  logic [3:0]         state_r, state_nxt;
  logic [NB-1:0]      sweep_r, sweep_nxt;
  logic [CB-1:0]      ecnt_r, ecnt_nxt;
  logic               dropped_r, dropped_nxt;
  logic [LIMIT_W-1:0] limit_r;
  logic [NB-1:0]      src_r, src_nxt, tgt_r, tgt_nxt;
  logic [COST_W-1:0]  cost_r, cost_nxt;
  logic [NB-1:0]      qh_r, qh_nxt;
  logic [QB-1:0]      qn_r, qn_nxt;
  logic [LIMIT_W-1:0] done_r, done_nxt;
  logic               limited_r, limited_nxt;
  logic [NB-1:0]      u_r, u_nxt, et_r, et_nxt;
  logic signed [DW-1:0] du_r, du_nxt;
  logic [EB-1:0]      link_r, link_nxt;
  logic               lok_r, lok_nxt;

  logic            nm_we, hm_we, em_we, qm_we;
  logic [NB-1:0]   nm_wa, nm_ra, hm_wa, hm_ra, qm_wa, qm_ra;
  logic [EB-1:0]   em_wa, em_ra;
  logic [NMW-1:0]  nm_wd, nm_rd;
  logic [HW-1:0]   hm_wd, hm_rd;
  logic [EW-1:0]   em_wd, em_rd;
  logic [NB-1:0]   qm_wd, qm_rd;

  logic signed [DW-1:0] nd_dist, nd_new;
  logic                 nd_mark;
  logic signed [DW:0]   sum_w;
  logic [QB:0]          tail_w;
  logic [NB-1:0]        tail_idx;
  logic signed [63:0]   d_wide;
  logic                 cfg_we;

  spfa_ram #(.WIDTH(NMW), .DEPTH(NODES)) u_node_ram (
    .clk, .we(nm_we), .waddr(nm_wa), .wdata(nm_wd), .raddr(nm_ra), .rdata(nm_rd));
  spfa_ram #(.WIDTH(HW), .DEPTH(NODES)) u_head_ram (
    .clk, .we(hm_we), .waddr(hm_wa), .wdata(hm_wd), .raddr(hm_ra), .rdata(hm_rd));
  spfa_ram #(.WIDTH(EW), .DEPTH(EDGES)) u_edge_ram (
    .clk, .we(em_we), .waddr(em_wa), .wdata(em_wd), .raddr(em_ra), .rdata(em_rd));
  spfa_ram #(.WIDTH(NB), .DEPTH(NODES)) u_queue_ram (
    .clk, .we(qm_we), .waddr(qm_wa), .wdata(qm_wd), .raddr(qm_ra), .rdata(qm_rd));

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? 32'(limit_r) : 32'd0;

  assign nd_mark = nm_rd[DW];
  assign nd_dist = signed'(nm_rd[DW-1:0]);

  // saturating add of distance and edge cost
  always_comb begin
    sum_w = {du_r[DW-1], du_r} + (DW+1)'(signed'(cost_r));
    if (!cost_r[COST_W-1] && (cost_r != '0) && (sum_w > MAXV)) begin
      nd_new = MAXV[DW-1:0];
    end else if (cost_r[COST_W-1] && (sum_w < MINV)) begin
      nd_new = MINV[DW-1:0];
    end else begin
      nd_new = sum_w[DW-1:0];
    end
  end

  assign tail_w   = (QB+1)'(qh_r) + (QB+1)'(qn_r);
  assign tail_idx = (tail_w >= (QB+1)'(NODES)) ? NB'(tail_w - (QB+1)'(NODES)) : NB'(tail_w);

  always_comb begin
    state_nxt   = state_r;
    sweep_nxt   = sweep_r;
    ecnt_nxt    = ecnt_r;
    dropped_nxt = dropped_r;
    src_nxt     = src_r;
    tgt_nxt     = tgt_r;
    cost_nxt    = cost_r;
    qh_nxt      = qh_r;
    qn_nxt      = qn_r;
    done_nxt    = done_r;
    limited_nxt = limited_r;
    u_nxt       = u_r;
    et_nxt      = et_r;
    du_nxt      = du_r;
    link_nxt    = link_r;
    lok_nxt     = lok_r;
    nm_we = 1'b0; nm_wa = '0; nm_wd = '0; nm_ra = tgt_r;
    hm_we = 1'b0; hm_wa = '0; hm_wd = '0; hm_ra = src_r;
    em_we = 1'b0; em_wa = '0; em_wd = '0; em_ra = link_r;
    qm_we = 1'b0; qm_wa = '0; qm_wd = '0; qm_ra = qh_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          src_nxt  = node_wrap(in_from_node);
          tgt_nxt  = node_wrap(in_to_node);
          cost_nxt = in_weight;
          hm_ra    = node_wrap(in_from_node);
          case (in_opcode)
            OP_CLEAR: begin
              ecnt_nxt    = '0;
              dropped_nxt = 1'b0;
              sweep_nxt   = '0;
              state_nxt   = S_CLR;
            end
            OP_ADD: begin
              if (ecnt_r >= CB'(EDGES)) begin
                dropped_nxt = 1'b1;
              end else begin
                state_nxt = S_ADD;
              end
            end
            OP_RUN: begin
              sweep_nxt = '0;
              state_nxt = S_INIT;
            end
            default: ;
          endcase
        end
      end
      S_CLR: begin
        hm_we = 1'b1;
        hm_wa = sweep_r;
        hm_wd = '0;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == NODE_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_ADD: begin
        em_we = 1'b1;
        em_wa = ecnt_r[EB-1:0];
        em_wd = {tgt_r, hm_rd[EB-1:0], hm_rd[EB], cost_r};
        hm_we = 1'b1;
        hm_wa = src_r;
        hm_wd = {1'b1, ecnt_r[EB-1:0]};
        ecnt_nxt  = ecnt_r + 1'b1;
        state_nxt = S_IDLE;
      end
      S_INIT: begin
        nm_we = 1'b1;
        nm_wa = sweep_r;
        nm_wd = {1'b0, INF_V};
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == NODE_LAST) begin
          state_nxt = S_SEED;
        end
      end
      S_SEED: begin
        nm_we = 1'b1;
        nm_wa = src_r;
        nm_wd = {1'b1, {DW{1'b0}}};
        qm_we = 1'b1;
        qm_wa = '0;
        qm_wd = src_r;
        qh_nxt      = '0;
        qn_nxt      = QB'(1);
        done_nxt    = '0;
        limited_nxt = 1'b0;
        state_nxt   = S_DEQ;
      end
      S_DEQ: begin
        if (qn_r == '0) begin
          state_nxt = S_FIN;
        end else if (done_r >= limit_r) begin
          limited_nxt = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          qm_ra     = qh_r;
          done_nxt  = done_r + 1'b1;
          qh_nxt    = (qh_r == NODE_LAST) ? '0 : qh_r + 1'b1;
          qn_nxt    = qn_r - 1'b1;
          state_nxt = S_DQ1;
        end
      end
      S_DQ1: begin
        u_nxt     = qm_rd;
        nm_ra     = qm_rd;
        hm_ra     = qm_rd;
        state_nxt = S_DQ2;
      end
      S_DQ2: begin
        du_nxt = nd_dist;
        nm_we  = 1'b1;
        nm_wa  = u_r;
        nm_wd  = {1'b0, nm_rd[DW-1:0]};
        if (hm_rd[EB]) begin
          em_ra     = hm_rd[EB-1:0];
          state_nxt = S_E1;
        end else begin
          state_nxt = S_DEQ;
        end
      end
      S_E1: begin
        et_nxt    = em_rd[EW-1 -: NB];
        link_nxt  = em_rd[COST_W+1 +: EB];
        lok_nxt   = em_rd[COST_W];
        cost_nxt  = em_rd[COST_W-1:0];
        nm_ra     = em_rd[EW-1 -: NB];
        state_nxt = S_E2;
      end
      S_E2: begin
        if (nd_new < nd_dist) begin
          nm_we = 1'b1;
          nm_wa = et_r;
          nm_wd = {nd_mark, nd_new};
          if (et_r == u_r) begin
            du_nxt = nd_new;
          end
          if (!nd_mark && (qn_r < QB'(NODES))) begin
            nm_wd  = {1'b1, nd_new};
            qm_we  = 1'b1;
            qm_wa  = tail_idx;
            qm_wd  = et_r;
            qn_nxt = qn_r + 1'b1;
          end
        end
        if (lok_r) begin
          em_ra     = link_r;
          state_nxt = S_E1;
        end else begin
          state_nxt = S_DEQ;
        end
      end
      S_FIN: begin
        nm_ra     = tgt_r;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      sweep_r   <= '0;
      ecnt_r    <= '0;
      dropped_r <= 1'b0;
      limit_r   <= LIMIT_RESET;
      qh_r      <= '0;
      qn_r      <= '0;
      done_r    <= '0;
      limited_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      sweep_r   <= sweep_nxt;
      ecnt_r    <= ecnt_nxt;
      dropped_r <= dropped_nxt;
      qh_r      <= qh_nxt;
      qn_r      <= qn_nxt;
      done_r    <= done_nxt;
      limited_r <= limited_nxt;
      if (cfg_we) begin
        limit_r <= pwdata[LIMIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    src_r  <= src_nxt;
    tgt_r  <= tgt_nxt;
    cost_r <= cost_nxt;
    u_r    <= u_nxt;
    et_r   <= et_nxt;
    du_r   <= du_nxt;
    link_r <= link_nxt;
    lok_r  <= lok_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = (state_r == S_OUT);
  assign d_wide        = 64'(nd_dist);
  assign out_distance  = d_wide[OUT_D_W-1:0];
  assign out_reachable = (nd_dist < INF_V);
  assign out_status    = limited_r ? ST_LIMIT : (dropped_r ? ST_DROPPED : ST_OK);

  `SPFA_ASSERT(a_qn_bound, qn_r <= QB'(NODES), "queue count above node count")
  `SPFA_ASSERT(a_ecnt_bound, ecnt_r <= CB'(EDGES), "edge count above table size")
  `SPFA_ASSERT_NEXT(a_out_idle, out_valid, !busy && !out_valid, "result not single cycle")
  `SPFA_ASSERT_NEXT(a_run_busy, start && !busy && (in_opcode == OP_RUN), busy,
    "run accepted without going busy")
endmodule
`default_nettype wire
